FILE: rtl/core/line_edit_input_buffer_defines.svh
// Assertion macros shared by the line edit input buffer RTL.
// Depends on nothing; files that assert include it by name.
`ifndef LINE_EDIT_INPUT_BUFFER_DEFINES_SVH
`define LINE_EDIT_INPUT_BUFFER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define LEIB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("line edit buffer check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define LEIB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("line edit buffer check failed");

`endif

FILE: rtl/core/leib_pkg.sv
// Package for the line edit input buffer: key codes, result codes, defaults.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package leib_pkg;

	localparam int LEIB_BUF_DEPTH = 128;

	localparam logic [7:0] KEY_NUL    = 8'h00;
	localparam logic [7:0] KEY_SOH    = 8'h01;
	localparam logic [7:0] KEY_STX    = 8'h02;
	localparam logic [7:0] KEY_CTRL_D = 8'h04;
	localparam logic [7:0] KEY_CTRL_H = 8'h08;
	localparam logic [7:0] KEY_LF     = 8'h0A;
	localparam logic [7:0] KEY_CR     = 8'h0D;
	localparam logic [7:0] KEY_CTRL_P = 8'h10;
	localparam logic [7:0] KEY_CTRL_U = 8'h15;
	localparam logic [7:0] KEY_DEL    = 8'h7F;

	typedef enum logic {
		CMD_KEY = 1'b0,
		CMD_POP = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ECHO_NONE  = 2'd0,
		ECHO_CHAR  = 2'd1,
		ECHO_ERASE = 2'd2
	} echo_kind_t;

	typedef enum logic [1:0] {
		RD_NONE  = 2'd0,
		RD_DATA  = 2'd1,
		RD_EOF   = 2'd2,
		RD_EMPTY = 2'd3
	} read_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/line_edit_input_buffer.sv
// Line edit input buffer
//
// Canonical-mode keyboard line buffer. Input transfers on the s_ group carry
// either a keystroke (s_tuser = 0) or a reader pop (s_tuser = 1). Every input
// transfer yields exactly one result transfer on the m_ group: echo action,
// line commit and dump flags for keystrokes, or a popped byte / EOF / empty
// status for pops.
//
// An item passes the input register and then the result register before its
// result is offered. Throughput: one item per cycle while m_tready does not
// stall the result side, set by the single pass through the index logic and
// one line store write per cycle. The line store is a RAM read at the next read
// index every cycle, with a one-entry bypass for a write that lands on the slot
// being read.
//
// Reset: arst_n clears the three ring indices and both valid flags; store
// contents are left as they are, since only written slots are ever read.
// Stall: when m_tready is low, the result register holds, the input register
// holds its item, and s_tready drops once both are full. No transfer is lost.
`timescale 1ns / 1ps
`default_nettype none
`include "line_edit_input_buffer_defines.svh"

module line_edit_input_buffer #(
	parameter int BUF_DEPTH = leib_pkg::LEIB_BUF_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // key[7:0], first_of_read[8], zero fill
	input  wire logic        s_tuser,   // cmd[0]
	// result channel
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // echo_char[7:0], erase_count[15:8],
	                                    // line_ready[16], dump_request[17],
	                                    // read_data[25:18], line_end[26], zero fill
	output logic      [3:0]  m_tuser    // echo_kind[1:0], read_status[3:2]
);

	import leib_pkg::*;

	// Ring indices run modulo twice the depth, so full and empty differ.
	localparam int IW = $clog2(2 * BUF_DEPTH);
	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int CW = (IW > 8) ? IW : 8;
	localparam logic [IW-1:0] IDX_LAST = IW'(2 * BUF_DEPTH - 1);
	localparam logic [IW-1:0] DEPTH_I  = IW'(BUF_DEPTH);
	localparam logic [IW:0]   MOD_W    = (IW + 1)'(2 * BUF_DEPTH);

	function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
		return (i == IDX_LAST) ? '0 : i + IW'(1);
	endfunction

	function automatic logic [IW-1:0] idx_dist(input logic [IW-1:0] a,
	                                           input logic [IW-1:0] b);
		logic [IW:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (d[IW]) begin
			d = d + MOD_W;
		end
		return d[IW-1:0];
	endfunction

	function automatic logic [AW-1:0] slot(input logic [IW-1:0] i);
		logic [IW-1:0] s;
		s = (i >= DEPTH_I) ? i - DEPTH_I : i;
		return s[AW-1:0];
	endfunction

	// input register
	logic       valid_s1;
	cmd_t       cmd_s1;
	logic [7:0] key_s1;
	logic       first_s1;

	// ring state
	logic [IW-1:0] read_q, commit_q, edit_q;
	logic [IW-1:0] read_n, commit_n, edit_n;

	// store access and write bypass
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;
	logic          hit_q;
	logic [7:0]    hit_data_q;
	logic [7:0]    head;

	// result register
	logic         out_valid_q;
	echo_kind_t   echo_kind_q, echo_kind_n;
	logic [7:0]   echo_char_q, echo_char_n;
	logic [7:0]   erase_count_q, erase_count_n;
	logic         line_ready_q, line_ready_n;
	logic         dump_request_q, dump_request_n;
	read_status_t read_status_q, read_status_n;
	logic [7:0]   read_data_q, read_data_n;
	logic         line_end_q, line_end_n;

	logic          advance;
	logic [IW-1:0] used, pending;
	logic [CW-1:0] pending_w;
	logic [7:0]    store_char;

	// Move the held item into the result register when that register frees.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= cmd_t'(s_tuser);
			key_s1   <= s_tdata[7:0];
			first_s1 <= s_tdata[8];
		end
	end

	// The RAM returns the slot addressed last cycle; a write to that slot in
	// the same cycle is taken from the bypass instead.
	assign head = hit_q ? hit_data_q : rdata;

	// Uncommitted text never holds LF (storing LF commits), so a kill erases
	// exactly the distance from commit to edit.
	assign used       = idx_dist(edit_q, read_q);
	assign pending    = idx_dist(edit_q, commit_q);
	assign pending_w  = CW'(pending);
	assign store_char = (key_s1 == KEY_CR) ? KEY_LF : key_s1;

	always_comb begin
		read_n         = read_q;
		commit_n       = commit_q;
		edit_n         = edit_q;
		we             = 1'b0;
		waddr          = slot(edit_q);
		wdata          = store_char;
		echo_kind_n    = ECHO_NONE;
		echo_char_n    = '0;
		erase_count_n  = '0;
		line_ready_n   = 1'b0;
		dump_request_n = 1'b0;
		read_status_n  = RD_NONE;
		read_data_n    = '0;
		line_end_n     = 1'b0;
		if (advance) begin
			case (cmd_s1)
				CMD_KEY: begin
					if (key_s1 == KEY_SOH || key_s1 == KEY_STX) begin
						// ignored keys
					end else if (key_s1 == KEY_CTRL_P) begin
						dump_request_n = 1'b1;
					end else if (key_s1 == KEY_CTRL_U) begin
						if (pending != '0) begin
							edit_n        = commit_q;
							echo_kind_n   = ECHO_ERASE;
							erase_count_n = (pending_w > CW'(255)) ? 8'd255 : pending_w[7:0];
						end
					end else if (key_s1 == KEY_CTRL_H || key_s1 == KEY_DEL) begin
						if (pending != '0) begin
							edit_n        = (edit_q == '0) ? IDX_LAST : edit_q - IW'(1);
							echo_kind_n   = ECHO_ERASE;
							erase_count_n = 8'd1;
						end
					end else if (key_s1 != KEY_NUL && used < DEPTH_I) begin
						we          = 1'b1;
						edit_n      = idx_inc(edit_q);
						echo_kind_n = ECHO_CHAR;
						echo_char_n = store_char;
						// commit on LF, ^D, or the byte that fills the ring
						if (store_char == KEY_LF || store_char == KEY_CTRL_D ||
						    used == DEPTH_I - IW'(1)) begin
							commit_n     = idx_inc(edit_q);
							line_ready_n = 1'b1;
						end
					end
				end
				CMD_POP: begin
					if (read_q == commit_q) begin
						read_status_n = RD_EMPTY;
					end else if (head == KEY_CTRL_D) begin
						read_status_n = RD_EOF;
						// leave a mid-read ^D for the next read request
						if (first_s1) begin
							read_n = idx_inc(read_q);
						end
					end else begin
						read_n        = idx_inc(read_q);
						read_status_n = RD_DATA;
						read_data_n   = head;
						line_end_n    = (head == KEY_LF);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Always read the slot the next read index points at.
	assign raddr = slot(read_n);

	leib_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_q   <= '0;
			commit_q <= '0;
			edit_q   <= '0;
			hit_q    <= 1'b0;
		end else begin
			read_q   <= read_n;
			commit_q <= commit_n;
			edit_q   <= edit_n;
			hit_q    <= we && (waddr == raddr);
		end
	end

	always_ff @(posedge clk) begin
		hit_data_q <= wdata;
	end

	// result register: fill on advance, drain on the receiver's transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			echo_kind_q    <= echo_kind_n;
			echo_char_q    <= echo_char_n;
			erase_count_q  <= erase_count_n;
			line_ready_q   <= line_ready_n;
			dump_request_q <= dump_request_n;
			read_status_q  <= read_status_n;
			read_data_q    <= read_data_n;
			line_end_q     <= line_end_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, line_end_q, read_data_q, dump_request_q, line_ready_q,
	                   erase_count_q, echo_char_q};
	assign m_tuser  = {read_status_q, echo_kind_q};

	// The ring never holds more than its depth, and committed text never
	// runs past the edit point.
	`LEIB_ASSERT_IMP(a_ring_bound, clk, arst_n, 1'b1, used <= DEPTH_I)
	`LEIB_ASSERT_IMP(a_commit_order, clk, arst_n, 1'b1,
		idx_dist(commit_q, read_q) <= used)
	// A commit brings the commit point up to the edit point.
	`LEIB_ASSERT_NXT(a_commit_meets_edit, clk, arst_n, advance && line_ready_n,
		commit_q == edit_q)
	// A pop that finds nothing committed leaves the read index alone.
	`LEIB_ASSERT_NXT(a_empty_pop_holds, clk, arst_n,
		advance && read_status_n == RD_EMPTY, read_q == $past(read_q))

endmodule

`default_nettype wire

FILE: rtl/core/leib_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module leib_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: tb/leib_tb_pkg.sv
// Scoreboard for the line edit input buffer testbench: a cycle-free model of the
// ring, its three indices, and the queue of responses still owed by the block.
// Depends on leib_pkg for key codes, command and result encodings.
`timescale 1ns / 1ps

package leib_tb_pkg;

	import leib_pkg::*;

	localparam int unsigned DEPTH    = LEIB_BUF_DEPTH;
	localparam int unsigned IDX_SPAN = 2 * DEPTH;

	typedef struct packed {
		echo_kind_t   kind;
		logic [7:0]   echo_char;
		logic [7:0]   erase_count;
		logic         line_ready;
		logic         dump_request;
		read_status_t rd_status;
		logic [7:0]   read_data;
		logic         line_end;
	} line_response_t;

	class line_buffer_scoreboard;
		logic [7:0]     ring [DEPTH];
		int unsigned    rd_ptr;
		int unsigned    commit_ptr;
		int unsigned    edit_ptr;
		line_response_t due_responses [$];
		line_response_t latest;
		int unsigned    errors;

		function new();
			rd_ptr = 0;
			commit_ptr = 0;
			edit_ptr = 0;
			errors = 0;
		endfunction

		function int unsigned ptr_back(int unsigned p);
			return (p + IDX_SPAN - 1) % IDX_SPAN;
		endfunction

		function int unsigned ptr_fwd(int unsigned p);
			return (p + 1) % IDX_SPAN;
		endfunction

		// bytes between the reader and the end of the line being typed
		function int unsigned held_bytes();
			return (edit_ptr + IDX_SPAN - rd_ptr) % IDX_SPAN;
		endfunction

		function int pending();
			return due_responses.size();
		endfunction

		// Work out the response to one accepted transfer and advance the ring.
		function void note_item(cmd_t cmd, logic [7:0] key, logic first_pop);
			line_response_t r;
			int unsigned    erased;
			logic [7:0]     ch;
			r = '0;
			r.kind = ECHO_NONE;
			r.rd_status = RD_NONE;
			if (cmd == CMD_KEY) begin
				if (key == KEY_SOH || key == KEY_STX) begin
					// history keys are not supported: no effect at all
				end else if (key == KEY_CTRL_P) begin
					r.dump_request = 1'b1;
				end else if (key == KEY_CTRL_U) begin
					erased = 0;
					while (edit_ptr != commit_ptr &&
							ring[ptr_back(edit_ptr) % DEPTH] != KEY_LF) begin
						edit_ptr = ptr_back(edit_ptr);
						erased++;
					end
					if (erased != 0) begin
						r.kind = ECHO_ERASE;
						r.erase_count = (erased > 255) ? 8'd255 : erased[7:0];
					end
				end else if (key == KEY_CTRL_H || key == KEY_DEL) begin
					if (edit_ptr != commit_ptr) begin
						edit_ptr = ptr_back(edit_ptr);
						r.kind = ECHO_ERASE;
						r.erase_count = 8'd1;
					end
				end else if (key != KEY_NUL && held_bytes() < DEPTH) begin
					ch = (key == KEY_CR) ? KEY_LF : key;
					ring[edit_ptr % DEPTH] = ch;
					edit_ptr = ptr_fwd(edit_ptr);
					r.kind = ECHO_CHAR;
					r.echo_char = ch;
					// newline, end of file or a full ring closes the line
					if (ch == KEY_LF || ch == KEY_CTRL_D || held_bytes() == DEPTH) begin
						commit_ptr = edit_ptr;
						r.line_ready = 1'b1;
					end
				end
			end else begin
				if (rd_ptr == commit_ptr) begin
					r.rd_status = RD_EMPTY;
				end else begin
					ch = ring[rd_ptr % DEPTH];
					if (ch == KEY_CTRL_D) begin
						// mid-read ^D stays put so the next read sees it first
						r.rd_status = RD_EOF;
						if (first_pop)
							rd_ptr = ptr_fwd(rd_ptr);
					end else begin
						rd_ptr = ptr_fwd(rd_ptr);
						r.rd_status = RD_DATA;
						r.read_data = ch;
						r.line_end = (ch == KEY_LF);
					end
				end
			end
			latest = r;
			due_responses.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		// Match one result transfer against the oldest outstanding response.
		function void check_result(logic [31:0] data, logic [3:0] user);
			line_response_t want;
			if (due_responses.size() == 0) begin
				$error("unexpected result: tdata %h tuser %h", data, user);
				errors++;
				return;
			end
			want = due_responses.pop_front();
			compare_field("echo_kind", 8'(want.kind), 8'(user[1:0]));
			compare_field("read_status", 8'(want.rd_status), 8'(user[3:2]));
			compare_field("echo_char", want.echo_char, data[7:0]);
			compare_field("erase_count", want.erase_count, data[15:8]);
			compare_field("line_ready", 8'(want.line_ready), 8'(data[16]));
			compare_field("dump_request", 8'(want.dump_request), 8'(data[17]));
			compare_field("read_data", want.read_data, data[25:18]);
			compare_field("line_end", 8'(want.line_end), 8'(data[26]));
			compare_field("tdata zero fill", 8'd0, 8'(data[31:27]));
		endfunction
	endclass

endpackage

FILE: tb/tb_top.sv
// Top of the line edit input buffer testbench: drives keystrokes and pops with
// bursty timing, stalls the result side, and checks every result in order.
// Depends on leib_pkg, leib_tb_pkg and the line_edit_input_buffer RTL.
`timescale 1ns / 1ps

module tb_top;

	import leib_pkg::*;
	import leib_tb_pkg::*;

	localparam int ITEM_TARGET = 1650;
	localparam int IDLE_LIMIT  = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // key[7:0], first_of_read[8], zero fill
	logic        s_tuser = 1'b0; // cmd[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // echo_char[7:0], erase_count[15:8], line_ready[16],
	                             // dump_request[17], read_data[25:18], line_end[26]
	logic [3:0]  m_tuser;        // echo_kind[1:0], read_status[3:2]

	line_buffer_scoreboard sb;

	int items_sent = 0;
	int burst_left = 0;
	int fills_done = 0;
	int idle_cycles = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int stall_phase = 0;

	line_edit_input_buffer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: switch now and then between randomly chosen stall patterns.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 4);
			mode_left = $urandom_range(20, 300);
		end else begin
			mode_left = mode_left - 1;
		end
		stall_phase = stall_phase + 1;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			3: m_tready <= (stall_phase % 5 != 2);
			default: m_tready <= (stall_phase % 32 >= 8);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	// Watchdog: give up when neither side moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Offer one transfer and hold it until accepted. Entered and left just
	// after a rising edge; a new burst may start with a random gap.
	task automatic push_item(cmd_t cmd, logic [7:0] key, logic first_pop);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {7'd0, first_pop, key};
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_item(cmd, key, first_pop);
		if (!(cmd == CMD_KEY && (key == KEY_SOH || key == KEY_STX)))
			items_sent++;
	endtask

	task automatic type_key(logic [7:0] key);
		push_item(CMD_KEY, key, 1'($urandom_range(0, 1)));
	endtask

	// Hold the sender until every outstanding response has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] text_key();
		if ($urandom_range(0, 99) < 85)
			return 8'($urandom_range(8'h20, 8'h7E));
		return 8'($urandom_range(8'h80, 8'hFF));
	endfunction

	// One typed line with edits sprinkled in, usually closed by a terminator.
	task automatic type_line();
		int len;
		int pick;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
		repeat (len) begin
			pick = $urandom_range(0, 99);
			if (pick < 75)
				type_key(text_key());
			else if (pick < 83)
				type_key($urandom_range(0, 1) ? KEY_CTRL_H : KEY_DEL);
			else if (pick < 86)
				type_key(KEY_CTRL_U);
			else if (pick < 88)
				type_key(KEY_CTRL_P);
			else if (pick < 90)
				type_key(KEY_NUL);
			else if (pick < 91)
				type_key($urandom_range(0, 1) ? KEY_SOH : KEY_STX);
			else
				type_key(8'($urandom_range(0, 255)));
		end
		pick = $urandom_range(0, 99);
		if (pick < 45)
			type_key(KEY_CR);
		else if (pick < 70)
			type_key(KEY_LF);
		else if (pick < 85)
			type_key(KEY_CTRL_D);
	endtask

	// A read request: pop until newline, end of file, nothing left committed, or
	// a random byte budget runs out. Now and then a stray first flag.
	task automatic read_request();
		int budget;
		push_item(CMD_POP, 8'($urandom_range(0, 255)), 1'b1);
		budget = $urandom_range(0, 30);
		while (budget > 0 && sb.latest.rd_status == RD_DATA && !sb.latest.line_end) begin
			push_item(CMD_POP, 8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
			budget--;
		end
	endtask

	// Type until the ring is full (the last byte commits), push past it, then
	// read everything back.
	task automatic fill_ring();
		while (sb.held_bytes() < DEPTH)
			type_key(text_key());
		type_key(text_key());
		type_key(KEY_CR);
		type_key(KEY_CTRL_U);
		type_key(KEY_DEL);
		do
			push_item(CMD_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		while (sb.latest.rd_status != RD_EMPTY);
		fills_done++;
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(1, 5))
			push_item(cmd_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
	endtask

	initial begin
		int pick;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, dropped and ignored keys, edits, commit paths, EOF
		push_item(CMD_POP, 8'hFF, 1'b1);
		type_key(KEY_NUL);
		type_key(KEY_SOH);
		type_key(KEY_STX);
		type_key(KEY_CTRL_P);
		type_key(KEY_CTRL_H);
		type_key(KEY_CTRL_U);
		type_key("a");
		type_key("b");
		type_key("c");
		type_key(KEY_DEL);
		type_key(KEY_CTRL_U);
		type_key(8'hFF);
		type_key(KEY_CR);
		type_key(KEY_DEL);
		push_item(CMD_POP, 8'h00, 1'b1);
		push_item(CMD_POP, 8'hFF, 1'b0);
		push_item(CMD_POP, 8'h00, 1'b0);
		type_key("x");
		type_key(KEY_CTRL_D);
		push_item(CMD_POP, 8'h00, 1'b1);
		push_item(CMD_POP, 8'h00, 1'b0);
		push_item(CMD_POP, 8'h00, 1'b1);
		type_key(KEY_LF);
		push_item(CMD_POP, 8'h00, 1'b1);
		drain_results();

		fill_ring();
		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)
				type_line();
			else if (pick < 75)
				read_request();
			else if (pick < 97)
				noise_burst();
			else if (pick == 97 && fills_done < 3)
				fill_ring();
			else
				drain_results();
		end

		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/leib_pkg.sv
rtl/core/leib_ram.sv
rtl/core/line_edit_input_buffer.sv
tb/leib_tb_pkg.sv
tb/tb_top.sv
